// ----- design/brush_stamp_spacer_assert.svh -----
// Assertion helpers used by brush_stamp_spacer.sv.
`ifndef BRUSH_STAMP_SPACER_ASSERT_SVH
`define BRUSH_STAMP_SPACER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bss_pkg.sv -----
`timescale 1ns / 1ps
package bss_pkg;

  localparam int UV_W       = 16;
  localparam int MAX_STAMPS = 64;
  localparam int CNT_W      = 7;
  localparam int IV_W       = 20;
  localparam int LIM_W      = 15;
  localparam int SQ_W       = 34;
  localparam int LEN_W      = 17;
  localparam int Q_W        = 15;
  localparam int NUM_W      = 30;
  localparam int SQ_STEPS   = 17;

  localparam logic [IV_W-1:0]  STEP_FLOOR = 20'd256;
  localparam logic [LIM_W-1:0] JUMP_MIN   = 15'd1966;
  localparam logic [LIM_W-1:0] JUMP_MAX   = 15'd16384;

  localparam logic [15:0] RADIUS_RST  = 16'd1638;
  localparam logic [15:0] SPACING_RST = 16'd1024;
  localparam logic [IV_W-1:0]  IV_RST  = 20'd409;
  localparam logic [LIM_W-1:0] LIM_RST = 15'd6552;

  localparam logic [1:0] MODE_BEGIN = 2'd0;
  localparam logic [1:0] MODE_MOVE  = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  localparam logic [2:0] REG_RADIUS  = 3'd0;
  localparam logic [2:0] REG_SPACING = 3'd1;
  localparam logic [2:0] REG_WRAP    = 3'd2;
  localparam logic [2:0] REG_SLOT    = 3'd3;
  localparam logic [2:0] REG_CHANNEL = 3'd4;

  localparam logic OP_SQRT = 1'b0;
  localparam logic OP_DIV  = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } bss_unit_ctrl_t;

  typedef struct packed {
    logic [IV_W-1:0]  interval;
    logic [LIM_W-1:0] jump_lim;
    logic             wrap;
    logic [7:0]       slot;
    logic [2:0]       chan;
  } bss_cfg_t;

endpackage

// ----- design/bss_cfg.sv -----
`timescale 1ns / 1ps
module bss_cfg import bss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output bss_cfg_t    cfg_o
);

  logic [15:0]      radius_r, spacing_r;
  logic             wrap_r;
  logic [7:0]       slot_r;
  logic [2:0]       chan_r;
  logic [IV_W-1:0]  iv_r, iv_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic [31:0]      prod;
  logic [17:0]      lim4;

  assign cfg_ready = 1'b1;

  always_comb begin
    prod = radius_r * spacing_r;
    iv_nxt = prod[31:12];
    if (iv_nxt < STEP_FLOOR) iv_nxt = STEP_FLOOR;
    lim4 = {radius_r, 2'b00};
    if (lim4 < {3'b000, JUMP_MIN}) begin
      lim_nxt = JUMP_MIN;
    end else if (lim4 > {3'b000, JUMP_MAX}) begin
      lim_nxt = JUMP_MAX;
    end else begin
      lim_nxt = lim4[LIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RADIUS_RST;
      spacing_r <= SPACING_RST;
      wrap_r    <= 1'b1;
      slot_r    <= 8'd0;
      chan_r    <= 3'd0;
      iv_r      <= IV_RST;
      lim_r     <= LIM_RST;
    end else begin
      iv_r  <= iv_nxt;
      lim_r <= lim_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_RADIUS:  radius_r  <= cfg_data;
          REG_SPACING: spacing_r <= cfg_data;
          REG_WRAP:    wrap_r    <= cfg_data[0];
          REG_SLOT:    slot_r    <= cfg_data[7:0];
          REG_CHANNEL: chan_r    <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o = '{interval: iv_r, jump_lim: lim_r, wrap: wrap_r, slot: slot_r, chan: chan_r};

endmodule

// ----- design/bss_unit.sv -----
`timescale 1ns / 1ps
module bss_unit import bss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  bss_unit_ctrl_t   ctrl,
  input  logic [SQ_W-1:0]  radicand,
  input  logic [NUM_W-1:0] numer,
  input  logic [LEN_W-1:0] divisor,
  output logic             done,
  output logic [LEN_W-1:0] result
);

  // One compare-subtract serves both the root and the quotient, one bit a step.
  logic             busy_r, done_r, op_r;
  logic [4:0]       cnt_r;
  logic [SQ_W-1:0]  x_r, root_r, bit_r;
  logic [LEN_W-1:0] div_r;
  logic [17:0]      sh;
  logic [SQ_W:0]    opa, opb, diff;
  logic             ge;

  always_comb begin
    sh = {x_r[16:0], bit_r[Q_W-1]};
    if (op_r == OP_DIV) begin
      opa = {17'd0, sh};
      opb = {18'd0, div_r};
    end else begin
      opa = {1'b0, x_r};
      opb = {1'b0, root_r | bit_r};
    end
    diff = opa - opb;
    ge   = !diff[SQ_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        op_r   <= ctrl.op;
        root_r <= '0;
        div_r  <= divisor;
        if (ctrl.op == OP_DIV) begin
          cnt_r <= 5'(Q_W - 1);
          x_r   <= {19'd0, numer[NUM_W-1:Q_W]};
          bit_r <= {19'd0, numer[Q_W-1:0]};
        end else begin
          cnt_r <= 5'(SQ_STEPS - 1);
          x_r   <= radicand;
          bit_r <= {2'b01, 32'd0};
        end
      end else if (busy_r) begin
        if (op_r == OP_DIV) begin
          x_r    <= ge ? diff[SQ_W-1:0] : {16'd0, sh};
          root_r <= {root_r[SQ_W-2:0], ge};
          bit_r  <= {bit_r[SQ_W-2:0], 1'b0};
        end else begin
          if (ge) x_r <= diff[SQ_W-1:0];
          root_r <= ge ? ((root_r >> 1) | bit_r) : (root_r >> 1);
          bit_r  <= bit_r >> 2;
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = root_r[LEN_W-1:0];

endmodule

// ----- design/brush_stamp_spacer.sv -----
// Brush stamp spacer: turns pointer events into evenly spaced brush stamps.
// Input channel (in_*): one pointer event per beat, taken when in_valid is high
// and in_stall low. in_stall stays high while an event is being worked on.
// Output channel (out_*): one stamp per beat; out_last_stamp marks the final
// stamp of an event. Events that produce no stamp give no output beat.
// Configuration (cfg_*): cfg_index selects radius, spacing, wrap, slot or
// channel; cfg_ready is always high. Write only while the block is idle.
// A begin event goes straight to its stamp; end and ignored events give none.
// A move takes two squarings and a 17-step square root in the shared
// unit, then per stamp two 15-step divisions in the same unit and one multiply
// each, for up to 64 stamps.
// The shared iterative unit sets the rate: one event at a time.
// A finished stamp waits in the output register; when it is full and out_stall
// is high, the block holds the next stamp and stops. Synchronous reset clears
// the stroke (idle, no last position, no island) and registers to defaults.
`timescale 1ns / 1ps
`include "brush_stamp_spacer_assert.svh"
module brush_stamp_spacer import bss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic        in_hit_valid,
  input  logic [7:0]  in_hit_slot,
  input  logic [2:0]  in_hit_channel,
  input  logic [15:0] in_pointer_u,
  input  logic [15:0] in_pointer_v,
  input  logic [15:0] in_hit_island,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_stamp_u,
  output logic [15:0] out_stamp_v,
  output logic [15:0] out_stamp_island,
  output logic        out_last_stamp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_MUL_U    = 4'd2;
  localparam logic [3:0] S_MUL_V    = 4'd3;
  localparam logic [3:0] S_SQ_GO    = 4'd4;
  localparam logic [3:0] S_SQ_WAIT  = 4'd5;
  localparam logic [3:0] S_CHECK    = 4'd6;
  localparam logic [3:0] S_LOOP     = 4'd7;
  localparam logic [3:0] S_MUL_O    = 4'd8;
  localparam logic [3:0] S_DIV_GO   = 4'd9;
  localparam logic [3:0] S_DIV_WAIT = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;

  bss_cfg_t       cfg;
  bss_unit_ctrl_t uctl;
  logic             u_done;
  logic [LEN_W-1:0] u_res;
  logic [NUM_W-1:0] numer;

  logic [3:0]  state_r;
  logic [1:0]  mode_r;
  logic        hit_r;
  logic [7:0]  slot_r;
  logic [2:0]  chan_r;
  logic [15:0] u_r, v_r, isl_r;

  logic             active_r;
  logic [15:0]      prev_u_r, prev_v_r, prev_isl_r;
  logic [IV_W-1:0]  dist_r, d_r;

  logic             negu_r, negv_r, ax_r, in_loop_r;
  logic [15:0]      magu_r, magv_r;
  logic [SQ_W-1:0]  sq_r;
  logic [LEN_W-1:0] len_r, rem_r, t_r;
  logic [CNT_W-1:0] n_r;
  logic [31:0]      prod_r;
  logic [Q_W-1:0]   qu_r;
  logic [15:0]      pu_r, pv_r, pisl_r;

  logic        out_valid_r, out_last_r;
  logic [15:0] out_u_r, out_v_r, out_isl_r;

  logic        match, go, load;
  logic [16:0] du, dv, du_w, dv_w;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [15:0] qv16;

  bss_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg_o(cfg)
  );

  bss_unit u_unit (
    .clk(clk), .rst_n(rst_n), .ctrl(uctl), .radicand(sq_r), .numer(numer),
    .divisor(len_r), .done(u_done), .result(u_res)
  );

  always_comb begin
    match = hit_r && (slot_r == cfg.slot) && (chan_r == cfg.chan);
    du = {1'b0, u_r} - {1'b0, prev_u_r};
    dv = {1'b0, v_r} - {1'b0, prev_v_r};
    // wrap: take the delta into [-0.5, 0.5)
    du_w = cfg.wrap ? {du[15], du[15:0]} : du;
    dv_w = cfg.wrap ? {dv[15], dv[15:0]} : dv;
    go = ({3'd0, rem_r} >= d_r) && (n_r < CNT_W'(MAX_STAMPS));
    case (state_r)
      S_MUL_U: begin mul_a = magu_r; mul_b = magu_r; end
      S_MUL_V: begin mul_a = magv_r; mul_b = magv_r; end
      default: begin mul_a = ax_r ? magv_r : magu_r; mul_b = t_r[15:0]; end
    endcase
    mul_p = mul_a * mul_b;
    numer = prod_r[NUM_W-1:0] + NUM_W'(len_r >> 1);
    uctl.start = (state_r == S_SQ_GO) || (state_r == S_DIV_GO);
    uctl.op    = (state_r == S_DIV_GO) ? OP_DIV : OP_SQRT;
    load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
    qv16 = {1'b0, u_res[Q_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      prev_u_r    <= 16'd0;
      prev_v_r    <= 16'd0;
      prev_isl_r  <= 16'hFFFF;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
      in_loop_r   <= 1'b0;
      n_r         <= '0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            hit_r   <= in_hit_valid;
            slot_r  <= in_hit_slot;
            chan_r  <= in_hit_channel;
            u_r     <= in_pointer_u;
            v_r     <= in_pointer_v;
            isl_r   <= in_hit_island;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_r <= S_IDLE;
          if (mode_r == MODE_BEGIN) begin
            if (!active_r && match) begin
              active_r   <= 1'b1;
              prev_u_r   <= u_r;
              prev_v_r   <= v_r;
              prev_isl_r <= isl_r;
              dist_r     <= cfg.interval;
              pu_r       <= u_r;
              pv_r       <= v_r;
              pisl_r     <= isl_r;
              in_loop_r  <= 1'b0;
              state_r    <= S_EMIT;
            end
          end else if (mode_r == MODE_END) begin
            active_r   <= 1'b0;
            prev_u_r   <= 16'd0;
            prev_v_r   <= 16'd0;
            prev_isl_r <= 16'hFFFF;
            dist_r     <= '0;
          end else if (mode_r == MODE_MOVE && active_r && match) begin
            negu_r  <= du_w[16];
            negv_r  <= dv_w[16];
            magu_r  <= du_w[16] ? 16'(-du_w) : du_w[15:0];
            magv_r  <= dv_w[16] ? 16'(-dv_w) : dv_w[15:0];
            state_r <= S_MUL_U;
          end
        end
        S_MUL_U: begin
          sq_r    <= {2'b00, mul_p};
          state_r <= S_MUL_V;
        end
        S_MUL_V: begin
          sq_r    <= sq_r + {2'b00, mul_p};
          state_r <= S_SQ_GO;
        end
        S_SQ_GO: state_r <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (u_done) begin
            len_r   <= u_res;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (isl_r != prev_isl_r || len_r > {2'b00, cfg.jump_lim}) begin
            // restart the stroke at the hit
            prev_u_r   <= u_r;
            prev_v_r   <= v_r;
            prev_isl_r <= isl_r;
            dist_r     <= cfg.interval;
            pu_r       <= u_r;
            pv_r       <= v_r;
            pisl_r     <= isl_r;
            in_loop_r  <= 1'b0;
            state_r    <= S_EMIT;
          end else begin
            rem_r     <= len_r;
            d_r       <= dist_r;
            t_r       <= '0;
            n_r       <= '0;
            in_loop_r <= 1'b1;
            state_r   <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (go) begin
            t_r <= t_r + d_r[LEN_W-1:0];
            rem_r <= rem_r - d_r[LEN_W-1:0];
            d_r <= cfg.interval;
            n_r <= n_r + CNT_W'(1);
            ax_r <= 1'b0;
            if (len_r == '0) begin
              pu_r    <= prev_u_r;
              pv_r    <= prev_v_r;
              pisl_r  <= prev_isl_r;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_MUL_O;
            end
          end else begin
            // drop any leftover when the stamp cap was hit
            dist_r     <= ({3'd0, rem_r} >= d_r) ? cfg.interval : d_r - {3'd0, rem_r};
            prev_u_r   <= u_r;
            prev_v_r   <= v_r;
            prev_isl_r <= isl_r;
            state_r    <= S_IDLE;
          end
        end
        S_MUL_O: begin
          prod_r  <= mul_p;
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (u_done) begin
            if (!ax_r) begin
              qu_r    <= u_res[Q_W-1:0];
              ax_r    <= 1'b1;
              state_r <= S_MUL_O;
            end else begin
              pu_r    <= negu_r ? prev_u_r - {1'b0, qu_r} : prev_u_r + {1'b0, qu_r};
              pv_r    <= negv_r ? prev_v_r - qv16 : prev_v_r + qv16;
              pisl_r  <= prev_isl_r;
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (load) state_r <= in_loop_r ? S_LOOP : S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_u_r    <= pu_r;
      out_v_r    <= pv_r;
      out_isl_r  <= pisl_r;
      out_last_r <= !in_loop_r || !go;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_stamp_u      = out_u_r;
  assign out_stamp_v      = out_v_r;
  assign out_stamp_island = out_isl_r;
  assign out_last_stamp   = out_last_r;

  `BSS_ASSERT_IMPL(a_unit_done_expected, u_done,
    (state_r == S_SQ_WAIT) || (state_r == S_DIV_WAIT), "unit result with nobody waiting")
  `BSS_ASSERT_IMPL(a_stamp_cap, 1'b1, n_r <= CNT_W'(MAX_STAMPS), "stamp count beyond cap")
  `BSS_ASSERT_IMPL(a_more_after_mid, out_valid_r && !out_last_r, state_r != S_IDLE,
    "idle while a stroke stamp is not the final one")
  `BSS_ASSERT_IMPL(a_rem_bound, state_r == S_LOOP && in_loop_r, rem_r <= len_r,
    "remaining distance exceeds segment length")
  `BSS_ASSERT_NEXT(a_accept_decodes, in_valid && !in_stall, state_r == S_DECODE,
    "accepted beat not decoded")

endmodule
